// File: hdl/rfb_pkg.sv
`timescale 1ns / 1ps
package rfb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    typedef enum logic [1:0] {
        KIND_FILL      = 2'd0,
        KIND_SWAP_ROWS = 2'd1,
        KIND_SWAP_COLS = 2'd2,
        KIND_READ      = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [8:0] extent_w;
        logic [8:0] extent_h;
        logic [7:0] first_line;
        logic [7:0] second_line;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd;

    typedef struct packed {
        logic       status;
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
    } t_result;

    typedef struct packed {
        logic [8:0] w;
        logic [8:0] h;
    } t_dims;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FILL,
        OP_SWAP_ROW,
        OP_SWAP_COL,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        status;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic [8:0]  x_end;
        logic [8:0]  y_end;
        logic [7:0]  line_a;
        logic [7:0]  line_b;
        logic [8:0]  len;
        logic [23:0] colour;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_RD,
        ST_RD_WAIT
    } t_state;

endpackage

// File: hdl/rfb_front.sv
`timescale 1ns / 1ps
module rfb_front (
    input  rfb_pkg::t_cmd  i_cmd,
    input  rfb_pkg::t_dims i_dims,
    output rfb_pkg::t_job  o_job
);
    import rfb_pkg::*;

    logic [9:0] right;
    logic [9:0] bottom;
    logic       x_in;
    logic       y_in;
    logic       l1_row;
    logic       l2_row;
    logic       l1_col;
    logic       l2_col;

    assign right  = {2'b00, i_cmd.pos_x} + {1'b0, i_cmd.extent_w};
    assign bottom = {2'b00, i_cmd.pos_y} + {1'b0, i_cmd.extent_h};
    assign x_in   = {1'b0, i_cmd.pos_x} < i_dims.w;
    assign y_in   = {1'b0, i_cmd.pos_y} < i_dims.h;
    assign l1_row = {1'b0, i_cmd.first_line} < i_dims.h;
    assign l2_row = {1'b0, i_cmd.second_line} < i_dims.h;
    assign l1_col = {1'b0, i_cmd.first_line} < i_dims.w;
    assign l2_col = {1'b0, i_cmd.second_line} < i_dims.w;

    always_comb begin
        o_job        = '0;
        o_job.op     = OP_NONE;
        o_job.status = STATUS_OK;
        o_job.x0     = i_cmd.pos_x;
        o_job.y0     = i_cmd.pos_y;
        o_job.x_end  = (right > {1'b0, i_dims.w}) ? i_dims.w : right[8:0];
        o_job.y_end  = (bottom > {1'b0, i_dims.h}) ? i_dims.h : bottom[8:0];
        o_job.line_a = i_cmd.first_line;
        o_job.line_b = i_cmd.second_line;
        o_job.colour = {i_cmd.red, i_cmd.green, i_cmd.blue};
        case (i_cmd.kind)
            KIND_FILL: begin
                if (x_in && y_in && i_cmd.extent_w != '0 && i_cmd.extent_h != '0) begin
                    o_job.op = OP_FILL;
                end
            end
            KIND_SWAP_ROWS: begin
                o_job.len = i_dims.w;
                if (!l1_row || !l2_row) begin
                    o_job.status = STATUS_INVALID;
                end else if (i_cmd.first_line != i_cmd.second_line && i_dims.w != '0) begin
                    o_job.op = OP_SWAP_ROW;
                end
            end
            KIND_SWAP_COLS: begin
                o_job.len = i_dims.h;
                if (!l1_col || !l2_col) begin
                    o_job.status = STATUS_INVALID;
                end else if (i_cmd.first_line != i_cmd.second_line && i_dims.h != '0) begin
                    o_job.op = OP_SWAP_COL;
                end
            end
            KIND_READ: begin
                if (x_in && y_in) begin
                    o_job.op = OP_READ;
                end else begin
                    o_job.status = STATUS_INVALID;
                end
            end
            default: begin
                o_job.op = OP_NONE;
            end
        endcase
    end

endmodule

// File: hdl/rfb_queue.sv
`timescale 1ns / 1ps
module rfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rfb_pkg::t_job i_job,
    input  logic          i_pop,
    output rfb_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import rfb_pkg::*;

    t_job       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// File: hdl/rfb_back.sv
`timescale 1ns / 1ps
module rfb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfb_pkg::t_dims   i_dims,
    input  rfb_pkg::t_job    i_job,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_done,
    output rfb_pkg::t_result o_result
);
    import rfb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [23:0] mem [DEPTH];

    t_state      r_state, n_state;
    t_job        r_job, n_job;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_k, n_k;
    logic [23:0] r_tmp, n_tmp;
    logic        r_done, n_done;
    t_result     r_res, n_res;
    logic [23:0] r_rdata;

    logic [7:0]  row_sel;
    logic [7:0]  col_sel;
    logic [16:0] lin;
    logic [AW-1:0] addr;
    logic        we;
    logic [23:0] wdata;
    logic        side_a;

    assign lin  = 17'(row_sel) * 17'(i_dims.w) + 17'(col_sel);
    assign addr = AW'(lin);
    assign side_a = (r_state == ST_SW_RA) || (r_state == ST_SW_WA);

    assign o_done   = r_done;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_row <= n_row;
        r_col <= n_col;
        r_k   <= n_k;
        r_tmp <= n_tmp;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        r_rdata <= mem[addr];
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        n_tmp   = r_tmp;
        n_done  = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        we      = 1'b0;
        wdata   = r_job.colour;
        row_sel = r_row;
        col_sel = r_col;

        if (r_job.op == OP_SWAP_ROW) begin
            if (r_state != ST_IDLE && r_state != ST_FILL && r_state != ST_RD
                    && r_state != ST_RD_WAIT) begin
                col_sel = r_k;
                row_sel = side_a ? r_job.line_a : r_job.line_b;
            end
        end else if (r_job.op == OP_SWAP_COL) begin
            if (r_state != ST_IDLE && r_state != ST_FILL && r_state != ST_RD
                    && r_state != ST_RD_WAIT) begin
                row_sel = r_k;
                col_sel = side_a ? r_job.line_a : r_job.line_b;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_row = i_job.y0;
                    n_col = i_job.x0;
                    n_k   = '0;
                    case (i_job.op)
                        OP_FILL:     n_state = ST_FILL;
                        OP_SWAP_ROW: n_state = ST_SW_RA;
                        OP_SWAP_COL: n_state = ST_SW_RA;
                        OP_READ:     n_state = ST_RD;
                        default: begin
                            n_done = 1'b1;
                            n_res  = '{status: i_job.status, default: '0};
                        end
                    endcase
                end
            end
            ST_FILL: begin
                we = 1'b1;
                if ({1'b0, r_col} + 9'd1 == r_job.x_end) begin
                    n_col = r_job.x0;
                    if ({1'b0, r_row} + 9'd1 == r_job.y_end) begin
                        n_state = ST_IDLE;
                        n_done  = 1'b1;
                        n_res   = '{status: STATUS_OK, default: '0};
                    end else begin
                        n_row = r_row + 8'd1;
                    end
                end else begin
                    n_col = r_col + 8'd1;
                end
            end
            ST_SW_RA: begin
                n_state = ST_SW_RB;
            end
            ST_SW_RB: begin
                n_tmp   = r_rdata;
                n_state = ST_SW_WA;
            end
            ST_SW_WA: begin
                we      = 1'b1;
                wdata   = r_rdata;
                n_state = ST_SW_WB;
            end
            ST_SW_WB: begin
                we    = 1'b1;
                wdata = r_tmp;
                if ({1'b0, r_k} + 9'd1 == r_job.len) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_res   = '{status: STATUS_OK, default: '0};
                end else begin
                    n_k     = r_k + 8'd1;
                    n_state = ST_SW_RA;
                end
            end
            ST_RD: begin
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_res   = {STATUS_OK, r_rdata};
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rgb_framebuffer_fill_and_line_swap_top.sv
`timescale 1ns / 1ps
// A command with no store access finishes from idle; a read addresses the store,
// then returns it; a fill writes each pixel; a swap reads, then writes, each pair.
// One store access per cycle on the back sequencer sets the rate; a 2-item
// queue lets start be taken while the sequencer works. The receiver cannot stall.
// Synchronous active-low reset clears control and sets width and height to 256;
// pixel contents are undefined until written, with no clearing pass.
module rgb_framebuffer_fill_and_line_swap_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rfb_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output rfb_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [8:0]       i_cfg_data
);
    import rfb_pkg::*;

    logic [8:0] r_width;
    logic [8:0] r_height;
    t_dims      dims;
    t_job       front_job;
    t_job       queue_job;
    logic       q_empty;
    logic       q_full;
    logic       pop;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;

    assign dims.w = (32'(r_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : r_width;
    assign dims.h = (32'(r_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    rfb_front u_front (
        .i_cmd  (i_cmd),
        .i_dims (dims),
        .o_job  (front_job)
    );

    rfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (dims),
        .i_job    (queue_job),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: verif/rfb_blit_checker.sv
`timescale 1ns / 1ps
module rfb_blit_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  rfb_pkg::t_cmd    i_cmd,
    input  logic             i_done,
    input  rfb_pkg::t_result i_result,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [8:0]       i_cfg_data,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);
    import rfb_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [23:0] pixels [0:DEPTH-1];
    logic [8:0]  img_w = 9'd256;
    logic [8:0]  img_h = 9'd256;
    t_result     expected_results [$];
    int unsigned fail_total = 0;

    initial begin
        for (int unsigned i = 0; i < DEPTH; i++) begin
            pixels[i] = '0;
        end
    end

    function automatic int unsigned eff_w();
        return (img_w > MAX_WIDTH) ? MAX_WIDTH : int'(img_w);
    endfunction

    function automatic int unsigned eff_h();
        return (img_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h);
    endfunction

    function automatic int unsigned pix_addr(int unsigned col, int unsigned row);
        int unsigned a;
        a = row * eff_w() + col;
        return (a < DEPTH) ? a : 0;
    endfunction

    task automatic swap_pixels(int unsigned a, int unsigned b);
        logic [23:0] tmp;
        tmp       = pixels[a];
        pixels[a] = pixels[b];
        pixels[b] = tmp;
    endtask

    task automatic predict_blit(input t_cmd c, output t_result r);
        int unsigned w, h, right, bottom;
        logic [23:0] pix;
        w   = eff_w();
        h   = eff_h();
        pix = '0;
        r   = '0;
        r.status = STATUS_OK;
        case (c.kind)
            KIND_FILL: begin
                if (c.pos_x < w && c.pos_y < h) begin
                    right  = c.pos_x + c.extent_w;
                    bottom = c.pos_y + c.extent_h;
                    if (right > w) begin
                        right = w;
                    end
                    if (bottom > h) begin
                        bottom = h;
                    end
                    for (int unsigned row = c.pos_y; row < bottom; row++) begin
                        for (int unsigned col = c.pos_x; col < right; col++) begin
                            pixels[pix_addr(col, row)] = {c.red, c.green, c.blue};
                        end
                    end
                end
            end
            KIND_SWAP_ROWS: begin
                if (c.first_line >= h || c.second_line >= h) begin
                    r.status = STATUS_INVALID;
                end else if (c.first_line != c.second_line) begin
                    for (int unsigned k = 0; k < w; k++) begin
                        swap_pixels(pix_addr(k, c.first_line), pix_addr(k, c.second_line));
                    end
                end
            end
            KIND_SWAP_COLS: begin
                if (c.first_line >= w || c.second_line >= w) begin
                    r.status = STATUS_INVALID;
                end else if (c.first_line != c.second_line) begin
                    for (int unsigned k = 0; k < h; k++) begin
                        swap_pixels(pix_addr(c.first_line, k), pix_addr(c.second_line, k));
                    end
                end
            end
            default: begin
                if (c.pos_x >= w || c.pos_y >= h) begin
                    r.status = STATUS_INVALID;
                end else begin
                    pix = pixels[pix_addr(c.pos_x, c.pos_y)];
                end
            end
        endcase
        r.read_red   = pix[23:16];
        r.read_green = pix[15:8];
        r.read_blue  = pix[7:0];
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            img_w = 9'd256;
            img_h = 9'd256;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: unexpected result, status %0d rgb %02h%02h%02h", $time,
                                 i_result.status, i_result.read_red, i_result.read_green,
                                 i_result.read_blue);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_result.status || want.read_red !== i_result.read_red ||
                        want.read_green !== i_result.read_green ||
                        want.read_blue !== i_result.read_blue) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: expected %0d %02h%02h%02h, got %0d %02h%02h%02h",
                                     $time, want.status, want.read_red, want.read_green,
                                     want.read_blue, i_result.status, i_result.read_red,
                                     i_result.read_green, i_result.read_blue);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_WIDTH:  img_w = i_cfg_data;
                    CFG_HEIGHT: img_h = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_start && !i_busy) begin
                predict_blit(i_cmd, fresh);
                expected_results.push_back(fresh);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/rgb_framebuffer_fill_and_line_swap_top_tb.sv
`timescale 1ns / 1ps
module rgb_framebuffer_fill_and_line_swap_top_tb;
    import rfb_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_cmd        i_cmd       = '0;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;
    logic [8:0]  cur_w = 9'd256;
    logic [8:0]  cur_h = 9'd256;

    always #5 i_clk = ~i_clk;

    rgb_framebuffer_fill_and_line_swap_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rfb_blit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int unsigned eff_dim(logic [8:0] v);
        return (v > 9'd256) ? 256 : int'(v);
    endfunction

    function automatic t_cmd mk_cmd(t_kind kind, int unsigned x, int unsigned y,
                                    int unsigned ew, int unsigned eh, int unsigned l1,
                                    int unsigned l2, logic [23:0] colour);
        t_cmd c;
        c.kind        = kind;
        c.pos_x       = 8'(x);
        c.pos_y       = 8'(y);
        c.extent_w    = 9'(ew);
        c.extent_h    = 9'(eh);
        c.first_line  = 8'(l1);
        c.second_line = 8'(l2);
        {c.red, c.green, c.blue} = colour;
        return c;
    endfunction

    // mostly in range, now and then anywhere in the field
    function automatic logic [7:0] pick_index(int unsigned lim);
        if (lim == 0 || $urandom_range(0, 7) == 0) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, lim - 1));
    endfunction

    // wide images get narrow extents to keep fills short
    function automatic logic [8:0] pick_extent(int unsigned lim);
        int unsigned r;
        if (lim > 32) begin
            return 9'($urandom_range(0, 16));
        end
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return 9'd256;
        end
        if (r == 1) begin
            return 9'($urandom_range(0, 256));
        end
        return 9'($urandom_range(0, lim + 1));
    endfunction

    function automatic t_cmd rand_blit_cmd();
        t_cmd c;
        int unsigned w, h, sel;
        w = eff_dim(cur_w);
        h = eff_dim(cur_h);
        c.kind        = KIND_READ;
        c.pos_x       = 8'($urandom);
        c.pos_y       = 8'($urandom);
        c.extent_w    = 9'($urandom_range(0, 256));
        c.extent_h    = 9'($urandom_range(0, 256));
        c.first_line  = 8'($urandom);
        c.second_line = 8'($urandom);
        c.red         = 8'($urandom);
        c.green       = 8'($urandom);
        c.blue        = 8'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            c.kind     = KIND_FILL;
            c.pos_x    = pick_index(w);
            c.pos_y    = pick_index(h);
            c.extent_w = pick_extent(w);
            c.extent_h = pick_extent(h);
        end else if (sel < 7) begin
            c.kind        = (sel < 5) ? KIND_SWAP_ROWS : KIND_SWAP_COLS;
            c.first_line  = pick_index((sel < 5) ? h : w);
            c.second_line = ($urandom_range(0, 9) == 0) ? c.first_line
                                                         : pick_index((sel < 5) ? h : w);
        end else begin
            c.pos_x = pick_index(w);
            c.pos_y = pick_index(h);
        end
        return c;
    endfunction

    task automatic send_cmd(t_cmd c, int unsigned max_gap);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_block();
        int unsigned cnt;
        cnt = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            cnt++;
        end while (pending != 0 && cnt < 20000);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [8:0] w, logic [8:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    initial begin
        t_cmd        directed [$];
        logic [8:0]  pw, ph;
        int unsigned max_gap, r;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // whole image written first, then clipping, swaps and reads at full size
        directed.push_back(mk_cmd(KIND_FILL, 0, 0, 256, 256, 0, 0, 24'h123456));
        directed.push_back(mk_cmd(KIND_FILL, 255, 255, 256, 256, 0, 0, 24'hFFFFFF));
        directed.push_back(mk_cmd(KIND_FILL, 0, 0, 0, 7, 0, 0, 24'h000000));
        directed.push_back(mk_cmd(KIND_FILL, 5, 5, 3, 0, 0, 0, 24'hABCDEF));
        directed.push_back(mk_cmd(KIND_FILL, 0, 0, 1, 1, 0, 0, 24'hFF00FF));
        directed.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 255, 255, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_ROWS, 0, 0, 0, 0, 0, 255, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_COLS, 0, 0, 0, 0, 0, 255, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_ROWS, 0, 0, 0, 0, 9, 9, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_COLS, 0, 0, 0, 0, 200, 200, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 255, 255, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 24'h0));
        foreach (directed[i]) begin
            send_cmd(directed[i], 13);
        end
        drain_block();

        // small image: edges, range checks, clipping
        set_dims(9'd8, 9'd4);
        directed.delete();
        directed.push_back(mk_cmd(KIND_FILL, 8, 0, 1, 1, 0, 0, 24'h0F0F0F));
        directed.push_back(mk_cmd(KIND_FILL, 0, 4, 1, 1, 0, 0, 24'hF0F0F0));
        directed.push_back(mk_cmd(KIND_FILL, 6, 2, 256, 256, 0, 0, 24'hAA550F));
        directed.push_back(mk_cmd(KIND_SWAP_ROWS, 0, 0, 0, 0, 0, 4, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_COLS, 0, 0, 0, 0, 8, 1, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_ROWS, 0, 0, 0, 0, 3, 1, 24'h0));
        directed.push_back(mk_cmd(KIND_SWAP_COLS, 0, 0, 0, 0, 7, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 8, 0, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 0, 4, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 7, 3, 0, 0, 0, 0, 24'h0));
        directed.push_back(mk_cmd(KIND_READ, 0, 1, 0, 0, 0, 0, 24'h0));
        foreach (directed[i]) begin
            send_cmd(directed[i], 13);
        end
        drain_block();

        for (int p = 0; p < 24; p++) begin
            case (p)
                0: begin pw = 9'd0;   ph = 9'd8;   end
                1: begin pw = 9'd8;   ph = 9'd0;   end
                2: begin pw = 9'd1;   ph = 9'd1;   end
                3: begin pw = 9'd511; ph = 9'd300; end
                4: begin pw = 9'd256; ph = 9'd256; end
                5: begin pw = 9'd32;  ph = 9'd32;  end
                6: begin pw = 9'd0;   ph = 9'd0;   end
                default: begin
                    r = $urandom_range(0, 19);
                    if (r < 14) begin
                        pw = 9'($urandom_range(1, 32));
                        ph = 9'($urandom_range(1, 32));
                    end else if (r < 17) begin
                        pw = 9'($urandom_range(33, 511));
                        ph = 9'($urandom_range(1, 32));
                        if (r == 16) begin
                            {pw, ph} = {ph, pw};
                        end
                    end else if (r < 19) begin
                        pw = 9'($urandom_range(33, 511));
                        ph = 9'($urandom_range(33, 511));
                    end else begin
                        pw = 9'($urandom_range(0, 1) ? 0 : $urandom_range(1, 32));
                        ph = (pw == 0) ? 9'($urandom_range(0, 32)) : 9'd0;
                    end
                end
            endcase
            set_dims(pw, ph);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 13;
            repeat (48) send_cmd(rand_blit_cmd(), max_gap);
            drain_block();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("** rgb_framebuffer_fill_and_line_swap_top: PASSED **");
        end else begin
            $display("** rgb_framebuffer_fill_and_line_swap_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("** rgb_framebuffer_fill_and_line_swap_top: FAILED **");
        $finish;
    end

endmodule
